// ===== hdl/sme_pkg.sv =====
// Shared constants, codes and types of the stack machine execute unit.
package sme_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_WORDS  = 256;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(DATA_WORDS);
  localparam int WORD_W      = 32;
  localparam int PC_W        = 16;
  localparam int KIND_W      = 5;
  localparam int ERR_W       = 3;

  // opcodes
  localparam logic [KIND_W-1:0] OP_HALT = 5'd0;
  localparam logic [KIND_W-1:0] OP_IN   = 5'd1;
  localparam logic [KIND_W-1:0] OP_OUT  = 5'd2;
  localparam logic [KIND_W-1:0] OP_ADD  = 5'd3;
  localparam logic [KIND_W-1:0] OP_SUB  = 5'd4;
  localparam logic [KIND_W-1:0] OP_MUL  = 5'd5;
  localparam logic [KIND_W-1:0] OP_DIV  = 5'd6;
  localparam logic [KIND_W-1:0] OP_DUP  = 5'd7;
  localparam logic [KIND_W-1:0] OP_LD   = 5'd8;
  localparam logic [KIND_W-1:0] OP_ST   = 5'd9;
  localparam logic [KIND_W-1:0] OP_LDC  = 5'd10;
  localparam logic [KIND_W-1:0] OP_JLT  = 5'd11;
  localparam logic [KIND_W-1:0] OP_JLE  = 5'd12;
  localparam logic [KIND_W-1:0] OP_JGT  = 5'd13;
  localparam logic [KIND_W-1:0] OP_JGE  = 5'd14;
  localparam logic [KIND_W-1:0] OP_JEQ  = 5'd15;
  localparam logic [KIND_W-1:0] OP_JNE  = 5'd16;
  localparam logic [KIND_W-1:0] OP_JMP  = 5'd17;

  // error codes
  localparam logic [ERR_W-1:0] ERR_OK      = 3'd0;
  localparam logic [ERR_W-1:0] ERR_ILLEGAL = 3'd1;
  localparam logic [ERR_W-1:0] ERR_UNDER   = 3'd2;
  localparam logic [ERR_W-1:0] ERR_OVER    = 3'd3;
  localparam logic [ERR_W-1:0] ERR_DIVZERO = 3'd4;
  localparam logic [ERR_W-1:0] ERR_ADDR    = 3'd5;

  // what a stack cell loads this cycle
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_TAKE_UP,
    CELL_TAKE_DN1,
    CELL_TAKE_DN2,
    CELL_TAKE_NEW
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// ===== hdl/sme_ifs.sv =====
// Handshake channels of the stack machine execute unit.
interface sme_in_if;
  logic                            valid;
  logic                            ready;
  logic [sme_pkg::KIND_W-1:0]      kind;
  logic signed [sme_pkg::WORD_W-1:0] arg;
  logic signed [sme_pkg::WORD_W-1:0] in_value;
  modport source (output valid, kind, arg, in_value, input ready);
  modport sink   (input valid, kind, arg, in_value, output ready);
endinterface

interface sme_out_if;
  logic                              valid;
  logic                              ready;
  logic                              out_valid;
  logic signed [sme_pkg::WORD_W-1:0] out_value;
  logic [sme_pkg::PC_W-1:0]          next_pc;
  logic                              halted;
  logic [sme_pkg::ERR_W-1:0]         error_code;
  modport source (output valid, out_valid, out_value, next_pc, halted, error_code,
                  input ready);
  modport sink   (input valid, out_valid, out_value, next_pc, halted, error_code,
                  output ready);
endinterface

// ===== hdl/stack_machine_execute_unit.sv =====
// Top level: decode, control sequencer, operand stack cell chain and data memory.
//
//  channel  | dir | carries
//  in_ch    | in  | kind, arg, in_value (one instruction)
//  out_ch   | out | out_valid, out_value, next_pc, halted, error_code
//
// An instruction passes from transfer to result through accept, execute and
// result held; DIV that divides also passes through the bit-serial divider.
// The data memory read is started from the top of stack on accept.
// Reset clears stack pointer, pc, halt flag and memory valid bits at once.
// A stalled result holds in the output register; no instruction is taken meanwhile.
module stack_machine_execute_unit (
  input  logic       clk,
  input  logic       rst_n,
  sme_in_if.sink     in_ch,
  sme_out_if.source  out_ch
);

  localparam int D = sme_pkg::STACK_DEPTH;
  localparam int W = sme_pkg::WORD_W;

  sme_pkg::state_t state_r, state_nxt;

  logic [sme_pkg::KIND_W-1:0] kind_r;
  logic [W-1:0]               arg_r, inv_r;
  logic [sme_pkg::SP_W-1:0]   sp_r, sp_nxt;
  logic [sme_pkg::PC_W-1:0]   pc_r, pc_nxt;
  logic                       halt_r, halt_nxt;

  logic [W-1:0] cell_q [D];
  logic [W-1:0] top, sec;
  sme_pkg::cell_op_t op0, opr, op0_eff, opr_eff;
  logic [W-1:0] new_word;

  logic [sme_pkg::ERR_W-1:0] err;
  logic                      ov;
  logic [W-1:0]              oval;
  logic                      mem_we, div_go, take;
  logic                      commit;
  logic [W-1:0]              mem_rdata, quot;
  logic                      div_done;

  logic                      ov_r;
  logic [W-1:0]              oval_r;
  logic [sme_pkg::PC_W-1:0]  npc_r;
  logic                      halted_r;
  logic [sme_pkg::ERR_W-1:0] err_r;

  assign top = cell_q[0];
  assign sec = cell_q[1];

  // instruction decode and next machine state
  always_comb begin
    err      = sme_pkg::ERR_OK;
    ov       = 1'b0;
    oval     = '0;
    pc_nxt   = pc_r + 1'b1;
    sp_nxt   = sp_r;
    halt_nxt = halt_r;
    op0      = sme_pkg::CELL_HOLD;
    opr      = sme_pkg::CELL_HOLD;
    new_word = '0;
    mem_we   = 1'b0;
    div_go   = 1'b0;
    take     = 1'b0;
    if (halt_r) begin
      pc_nxt = pc_r;
    end else begin
      unique case (kind_r)
        sme_pkg::OP_HALT: halt_nxt = 1'b1;
        sme_pkg::OP_IN, sme_pkg::OP_DUP, sme_pkg::OP_LDC: begin
          if (kind_r == sme_pkg::OP_DUP && sp_r == '0) err = sme_pkg::ERR_UNDER;
          else if (sp_r >= sme_pkg::SP_W'(D))          err = sme_pkg::ERR_OVER;
          else begin
            new_word = (kind_r == sme_pkg::OP_IN) ? inv_r :
                       (kind_r == sme_pkg::OP_DUP) ? top : arg_r;
            op0    = sme_pkg::CELL_TAKE_NEW;
            opr    = sme_pkg::CELL_TAKE_UP;
            sp_nxt = sp_r + 1'b1;
          end
        end
        sme_pkg::OP_OUT: begin
          if (sp_r == '0) err = sme_pkg::ERR_UNDER;
          else begin
            ov     = 1'b1;
            oval   = top;
            op0    = sme_pkg::CELL_TAKE_DN1;
            opr    = sme_pkg::CELL_TAKE_DN1;
            sp_nxt = sp_r - 1'b1;
          end
        end
        sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV: begin
          if (sp_r < sme_pkg::SP_W'(2)) err = sme_pkg::ERR_UNDER;
          else if (kind_r == sme_pkg::OP_DIV && top == '0) err = sme_pkg::ERR_DIVZERO;
          else begin
            unique case (kind_r)
              sme_pkg::OP_ADD: new_word = sec + top;
              sme_pkg::OP_SUB: new_word = sec - top;
              sme_pkg::OP_MUL: new_word = sec * top;
              default:         new_word = quot;
            endcase
            div_go = (kind_r == sme_pkg::OP_DIV);
            op0    = sme_pkg::CELL_TAKE_NEW;
            opr    = sme_pkg::CELL_TAKE_DN1;
            sp_nxt = sp_r - 1'b1;
          end
        end
        sme_pkg::OP_LD: begin
          if (sp_r == '0) err = sme_pkg::ERR_UNDER;
          else if (top >= W'(sme_pkg::DATA_WORDS)) err = sme_pkg::ERR_ADDR;
          else begin
            new_word = mem_rdata;
            op0      = sme_pkg::CELL_TAKE_NEW;
          end
        end
        sme_pkg::OP_ST: begin
          if (sp_r < sme_pkg::SP_W'(2)) err = sme_pkg::ERR_UNDER;
          else if (sec >= W'(sme_pkg::DATA_WORDS)) err = sme_pkg::ERR_ADDR;
          else begin
            mem_we = 1'b1;
            op0    = sme_pkg::CELL_TAKE_DN2;
            opr    = sme_pkg::CELL_TAKE_DN2;
            sp_nxt = sp_r - sme_pkg::SP_W'(2);
          end
        end
        sme_pkg::OP_JLT, sme_pkg::OP_JLE, sme_pkg::OP_JGT,
        sme_pkg::OP_JGE, sme_pkg::OP_JEQ, sme_pkg::OP_JNE: begin
          if (sp_r == '0) err = sme_pkg::ERR_UNDER;
          else begin
            unique case (kind_r)
              sme_pkg::OP_JLT: take = top[W-1];
              sme_pkg::OP_JLE: take = top[W-1] || (top == '0);
              sme_pkg::OP_JGT: take = !top[W-1] && (top != '0);
              sme_pkg::OP_JGE: take = !top[W-1];
              sme_pkg::OP_JEQ: take = (top == '0);
              default:         take = (top != '0);
            endcase
            if (take) pc_nxt = arg_r[sme_pkg::PC_W-1:0];
            op0    = sme_pkg::CELL_TAKE_DN1;
            opr    = sme_pkg::CELL_TAKE_DN1;
            sp_nxt = sp_r - 1'b1;
          end
        end
        sme_pkg::OP_JMP: pc_nxt = arg_r[sme_pkg::PC_W-1:0];
        default:         err = sme_pkg::ERR_ILLEGAL;
      endcase
      if (err != sme_pkg::ERR_OK) pc_nxt = pc_r;
    end
  end

  // commit once execution (or the divide) is finished
  assign commit  = (state_r == sme_pkg::ST_EXEC && !div_go) ||
                   (state_r == sme_pkg::ST_DIV && div_done);
  assign op0_eff = commit ? op0 : sme_pkg::CELL_HOLD;
  assign opr_eff = commit ? opr : sme_pkg::CELL_HOLD;

  // operand stack cell chain, top of stack in cell 0
  for (genvar i = 0; i < D; i++) begin : g_cell
    sme_cell u_cell (
      .clk      (clk),
      .op       ((i == 0) ? op0_eff : opr_eff),
      .new_word (new_word),
      .up_word  ((i == 0) ? new_word : cell_q[(i == 0) ? 0 : i - 1]),
      .dn1_word ((i + 1 < D) ? cell_q[(i + 1 < D) ? i + 1 : i] : '0),
      .dn2_word ((i + 2 < D) ? cell_q[(i + 2 < D) ? i + 2 : i] : '0),
      .word     (cell_q[i])
    );
  end

  sme_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == sme_pkg::ST_EXEC && div_go),
    .num   (sec),
    .den   (top),
    .done  (div_done),
    .quot  (quot)
  );

  sme_dmem u_dmem (
    .clk   (clk),
    .rst_n (rst_n),
    .raddr (top[sme_pkg::ADDR_W-1:0]),
    .rdata (mem_rdata),
    .we    (commit && mem_we),
    .waddr (sec[sme_pkg::ADDR_W-1:0]),
    .wdata (top)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sme_pkg::ST_IDLE: if (in_ch.valid) state_nxt = sme_pkg::ST_EXEC;
      sme_pkg::ST_EXEC: state_nxt = div_go ? sme_pkg::ST_DIV : sme_pkg::ST_OUT;
      sme_pkg::ST_DIV:  if (div_done) state_nxt = sme_pkg::ST_OUT;
      sme_pkg::ST_OUT:  if (out_ch.ready) state_nxt = sme_pkg::ST_IDLE;
      default:          state_nxt = sme_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ch.ready  = (state_r == sme_pkg::ST_IDLE);
    out_ch.valid = (state_r == sme_pkg::ST_OUT);
  end

  assign out_ch.out_valid  = ov_r;
  assign out_ch.out_value  = oval_r;
  assign out_ch.next_pc    = npc_r;
  assign out_ch.halted     = halted_r;
  assign out_ch.error_code = err_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sme_pkg::ST_IDLE;
      sp_r    <= '0;
      pc_r    <= '0;
      halt_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        pc_r   <= pc_nxt;
        halt_r <= halt_nxt;
        if (err == sme_pkg::ERR_OK) sp_r <= sp_nxt;
      end
    end
  end

  // instruction latch and result register
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      kind_r <= in_ch.kind;
      arg_r  <= in_ch.arg;
      inv_r  <= in_ch.in_value;
    end
    if (commit) begin
      ov_r     <= ov;
      oval_r   <= oval;
      npc_r    <= pc_nxt;
      halted_r <= halt_nxt;
      err_r    <= err;
    end
  end

endmodule

// ===== hdl/sme_cell.sv =====
// One operand stack cell: holds a word, loads from a neighbor or new data.
module sme_cell (
  input  logic                        clk,
  input  sme_pkg::cell_op_t           op,
  input  logic [sme_pkg::WORD_W-1:0]  new_word,
  input  logic [sme_pkg::WORD_W-1:0]  up_word,
  input  logic [sme_pkg::WORD_W-1:0]  dn1_word,
  input  logic [sme_pkg::WORD_W-1:0]  dn2_word,
  output logic [sme_pkg::WORD_W-1:0]  word
);

  logic [sme_pkg::WORD_W-1:0] word_r, word_nxt;

  always_comb begin
    unique case (op)
      sme_pkg::CELL_TAKE_UP:  word_nxt = up_word;
      sme_pkg::CELL_TAKE_DN1: word_nxt = dn1_word;
      sme_pkg::CELL_TAKE_DN2: word_nxt = dn2_word;
      sme_pkg::CELL_TAKE_NEW: word_nxt = new_word;
      default:                word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

// ===== hdl/sme_divider.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module sme_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [sme_pkg::WORD_W-1:0]  num,
  input  logic [sme_pkg::WORD_W-1:0]  den,
  output logic                        done,
  output logic [sme_pkg::WORD_W-1:0]  quot
);

  localparam int CNT_W = $clog2(sme_pkg::WORD_W + 1);

  logic [sme_pkg::WORD_W:0]   rem_r, rem_nxt;
  logic [sme_pkg::WORD_W-1:0] quo_r, quo_nxt, den_r, den_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt, neg_r, neg_nxt, done_r, done_nxt;
  logic [sme_pkg::WORD_W:0]   shifted;
  logic [sme_pkg::WORD_W:0]   diff;

  // one restoring step per cycle
  always_comb begin
    shifted  = {rem_r[sme_pkg::WORD_W-1:0], quo_r[sme_pkg::WORD_W-1]};
    diff     = shifted - {1'b0, den_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = num[sme_pkg::WORD_W-1] ? (~num + 1'b1) : num;
      den_nxt  = den[sme_pkg::WORD_W-1] ? (~den + 1'b1) : den;
      neg_nxt  = num[sme_pkg::WORD_W-1] ^ den[sme_pkg::WORD_W-1];
      cnt_nxt  = CNT_W'(sme_pkg::WORD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[sme_pkg::WORD_W]) begin
        rem_nxt = diff;
        quo_nxt = {quo_r[sme_pkg::WORD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[sme_pkg::WORD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

// ===== hdl/sme_dmem.sv =====
// Data memory with per-word valid bits; unwritten words read as zero.
module sme_dmem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [sme_pkg::ADDR_W-1:0]  raddr,
  output logic [sme_pkg::WORD_W-1:0]  rdata,
  input  logic                        we,
  input  logic [sme_pkg::ADDR_W-1:0]  waddr,
  input  logic [sme_pkg::WORD_W-1:0]  wdata
);

  logic [sme_pkg::WORD_W-1:0]     mem [sme_pkg::DATA_WORDS];
  logic [sme_pkg::DATA_WORDS-1:0] vld_r;
  logic [sme_pkg::WORD_W-1:0]     rd_r;
  logic                           rv_r;

  // write port and valid bits
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_r <= mem[raddr];
    if (!rst_n) rv_r <= 1'b0;
    else        rv_r <= vld_r[raddr];
  end

  assign rdata = rv_r ? rd_r : '0;

endmodule
